[sv/bdq_pkg.sv]
// Shared types and codes for the bounded double-ended queue.
// Used by the controller, the datapath and the top level; no dependencies.
package bdq_pkg;

   // Operation codes carried in the request
   localparam logic [2:0] FUNC_PUSH_BACK  = 3'd0;
   localparam logic [2:0] FUNC_POP_BACK   = 3'd1;
   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd2;
   localparam logic [2:0] FUNC_POP_FRONT  = 3'd3;
   localparam logic [2:0] FUNC_DELETE     = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_NOMATCH = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;       // latch the request transaction
      logic exec;         // carry out the latched operation
      logic pop_capture;  // take the popped entry from the read register
      logic scan;         // one step of the delete scan and compaction
      logic rsp_load;     // move the result into the output register
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [2:0] func;      // latched operation code
      logic       empty;     // no entries held
      logic       full;      // all entries held
      logic       scan_last; // last held entry is being compared
      logic       rsp_busy;  // output register holds a result not yet taken
   } dp_stat_type;

endpackage

[sv/bdq_ctrl.sv]
// Controller state machine for the bounded double-ended queue.
// Depends on bdq_pkg for the command and status structs and the operation codes.
module bdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bdq_pkg::dp_stat_type stat,
   output bdq_pkg::ctl_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_POPW = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic is_pop;
   logic is_delete;

   assign is_pop    = (stat.func == bdq_pkg::FUNC_POP_BACK) ||
                      (stat.func == bdq_pkg::FUNC_POP_FRONT);
   assign is_delete = (stat.func == bdq_pkg::FUNC_DELETE);

   // Sequence one transaction at a time through the datapath
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      req_tready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (is_pop && !stat.empty) begin
               state_in = ST_POPW;
            end else if (is_delete && !stat.empty) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_POPW: begin
            cmd.pop_capture = 1'b1;
            state_in        = ST_FIN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/bdq_dpath.sv]
// Datapath for the bounded double-ended queue: ring store, pointers,
// delete scan pipeline and output register. Depends on bdq_pkg.
module bdq_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bdq_pkg::ctl_cmd_type cmd,
   output bdq_pkg::dp_stat_type stat,
   input  logic [2:0]           req_func,
   input  logic signed [31:0]   req_value,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_value,
   output logic [4:0]           rsp_count,
   output logic [1:0]           rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Ring store
   logic signed [31:0] mem [DEPTH];
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic signed [31:0] mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;
   logic signed [31:0] rd_data_ff;

   // Latched request
   logic [2:0]         func_ff, func_in;
   logic signed [31:0] value_ff, value_in;

   // Queue pointers
   logic [AW-1:0]      front_ff, front_in;
   logic [CW-1:0]      occ_ff, occ_in;

   // Result being built
   logic signed [31:0] rem_ff, rem_in;
   logic [1:0]         status_ff, status_in;

   // Delete scan pipeline
   logic [AW-1:0]      rd_slot_ff, rd_slot_in;
   logic [CW-1:0]      rd_cnt_ff, rd_cnt_in;
   logic               cmp_v_ff, cmp_v_in;
   logic [AW-1:0]      cmp_slot_ff, cmp_slot_in;
   logic [CW-1:0]      cmp_cnt_ff, cmp_cnt_in;
   logic [AW-1:0]      prev_slot_ff, prev_slot_in;
   logic               found_ff, found_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               full;
   logic               empty;
   logic               scan_last;
   logic               match;

   function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [AW:0] sum;
      begin
         sum = {1'b0, base} + (AW + 1)'(off);
         if (sum >= (AW + 1)'(DEPTH)) begin
            sum = sum - (AW + 1)'(DEPTH);
         end
         return sum[AW-1:0];
      end
   endfunction

   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
      return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
   endfunction

   function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
      return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
   endfunction

   assign full      = (occ_ff == CW'(DEPTH));
   assign empty     = (occ_ff == '0);
   assign scan_last = cmp_v_ff && (cmp_cnt_ff == occ_ff - CW'(1));
   assign match     = (rd_data_ff == value_ff);

   assign stat.func      = func_ff;
   assign stat.empty     = empty;
   assign stat.full      = full;
   assign stat.scan_last = scan_last;
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_tready;

   always_comb begin
      func_in       = func_ff;
      value_in      = value_ff;
      front_in      = front_ff;
      occ_in        = occ_ff;
      rem_in        = rem_ff;
      status_in     = status_ff;
      rd_slot_in    = rd_slot_ff;
      rd_cnt_in     = rd_cnt_ff;
      cmp_v_in      = cmp_v_ff;
      cmp_slot_in   = cmp_slot_ff;
      cmp_cnt_in    = cmp_cnt_ff;
      prev_slot_in  = prev_slot_ff;
      found_in      = found_ff;
      mem_we        = 1'b0;
      mem_waddr     = front_ff;
      mem_wdata     = value_ff;
      mem_re        = 1'b0;
      mem_raddr     = front_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      // Latch the request transaction
      if (cmd.accept) begin
         func_in  = req_func;
         value_in = req_value;
      end

      // Carry out the operation
      if (cmd.exec) begin
         rem_in    = '0;
         status_in = bdq_pkg::STATUS_OK;
         case (func_ff)
            bdq_pkg::FUNC_PUSH_BACK: begin
               if (full) begin
                  status_in = bdq_pkg::STATUS_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = slot_add(front_ff, occ_ff);
                  occ_in    = occ_ff + CW'(1);
               end
            end
            bdq_pkg::FUNC_PUSH_FRONT: begin
               if (full) begin
                  status_in = bdq_pkg::STATUS_FULL;
               end else begin
                  front_in  = slot_dec(front_ff);
                  mem_we    = 1'b1;
                  mem_waddr = slot_dec(front_ff);
                  occ_in    = occ_ff + CW'(1);
               end
            end
            bdq_pkg::FUNC_POP_BACK: begin
               if (empty) begin
                  status_in = bdq_pkg::STATUS_EMPTY;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = slot_add(front_ff, occ_ff - CW'(1));
                  occ_in    = occ_ff - CW'(1);
               end
            end
            bdq_pkg::FUNC_POP_FRONT: begin
               if (empty) begin
                  status_in = bdq_pkg::STATUS_EMPTY;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = front_ff;
                  front_in  = slot_inc(front_ff);
                  occ_in    = occ_ff - CW'(1);
               end
            end
            bdq_pkg::FUNC_DELETE: begin
               if (empty) begin
                  status_in = bdq_pkg::STATUS_NOMATCH;
               end else begin
                  rd_slot_in = front_ff;
                  rd_cnt_in  = '0;
                  cmp_v_in   = 1'b0;
                  found_in   = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      // Take the popped entry
      if (cmd.pop_capture) begin
         rem_in = rd_data_ff;
      end

      // Scan: read one entry ahead, compare the one just read, shift after a match
      if (cmd.scan) begin
         if (rd_cnt_ff < occ_ff) begin
            mem_re      = 1'b1;
            mem_raddr   = rd_slot_ff;
            rd_slot_in  = slot_inc(rd_slot_ff);
            rd_cnt_in   = rd_cnt_ff + CW'(1);
            cmp_v_in    = 1'b1;
            cmp_slot_in = rd_slot_ff;
            cmp_cnt_in  = rd_cnt_ff;
         end else begin
            cmp_v_in = 1'b0;
         end
         if (cmp_v_ff) begin
            prev_slot_in = cmp_slot_ff;
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = prev_slot_ff;
               mem_wdata = rd_data_ff;
            end else if (match) begin
               found_in = 1'b1;
            end
         end
         if (scan_last) begin
            if (found_ff || match) begin
               occ_in = occ_ff - CW'(1);
            end else begin
               status_in = bdq_pkg::STATUS_NOMATCH;
            end
         end
      end

      // Hold or hand over the result transaction
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = rem_ff;
         rsp_count_in  = 5'(occ_ff);
         rsp_status_in = status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Ring store with registered read data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         occ_ff       <= '0;
         cmp_v_ff     <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         cmp_v_ff     <= cmp_v_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      rem_ff        <= rem_in;
      status_ff     <= status_in;
      rd_slot_ff    <= rd_slot_in;
      rd_cnt_ff     <= rd_cnt_in;
      cmp_slot_ff   <= cmp_slot_in;
      cmp_cnt_ff    <= cmp_cnt_in;
      prev_slot_ff  <= prev_slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule

[sv/bounded_deque_with_delete.sv]
// Bounded double-ended queue with delete-by-value, one result per request.
// Requests are handled one at a time: the next is taken only after the result of the last
// has entered the output register, and that waits while an earlier result is not yet taken.
// Synchronous active-high reset empties the queue; the store itself is not cleared.
module bounded_deque_with_delete #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] removed_value, [36:32] entry_count, zero fill
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   bdq_pkg::ctl_cmd_type cmd;
   bdq_pkg::dp_stat_type stat;

   logic signed [31:0] rsp_value;
   logic [4:0]         rsp_count;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_func   (req_tuser),
      .req_value  ($signed(req_tdata)),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_value  (rsp_value),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_tuser)
   );

   // Pack the result transaction
   assign rsp_tdata = {3'b000, rsp_count, rsp_value};

   // Only one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // A loaded result shows on the output
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_tvalid)
      else $error("result load did not raise rsp_tvalid");

   // The scan stops after the last entry is compared
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && stat.scan_last) |=> !cmd.scan)
      else $error("delete scan ran past the last entry");

   // A result is loaded only when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("result overwrote a pending output");

endmodule

[verif/tb.sv]
// Self-checking testbench for bounded_deque_with_delete: random and directed deque traffic,
// each result checked against a mirror of the ring store kept in a scoreboard class.
// Depends on bdq_pkg for the operation and status codes; needs nothing else but the RTL.

typedef struct packed {
   logic [31:0] removed_value;
   logic [4:0]  entry_count;
   logic [1:0]  status;
} deque_result_type;

class deque_scoreboard;
   int unsigned      depth;
   logic [31:0]      ring [];
   int unsigned      front;
   int unsigned      occupancy;
   deque_result_type awaited_results [$];
   int unsigned      mismatches;
   int unsigned      results_checked;
   int unsigned      requests_seen;
   int unsigned      status_seen [4];
   int unsigned      peak_occupancy;

   function new(int unsigned queue_depth);
      depth = queue_depth;
      ring  = new[queue_depth];
      front = 0;
      occupancy = 0;
      mismatches = 0;
      results_checked = 0;
      requests_seen = 0;
      peak_occupancy = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
   endfunction

   function int unsigned slot(int unsigned offset);
      return (front + offset) % depth;
   endfunction

   // Value held at a given distance from the front; only held entries are asked for
   function logic [31:0] held_value(int unsigned offset);
      return ring[slot(offset)];
   endfunction

   // Apply one operation to the mirror and return the result it gives
   function deque_result_type step_queue(logic [2:0] func, logic [31:0] value);
      deque_result_type res;
      int unsigned      pos;
      bit               found;
      res.removed_value = '0;
      res.status = bdq_pkg::STATUS_OK;
      found = 1'b0;
      pos = 0;
      case (func)
         bdq_pkg::FUNC_PUSH_BACK: begin
            if (occupancy >= depth) res.status = bdq_pkg::STATUS_FULL;
            else begin
               ring[slot(occupancy)] = value;
               occupancy++;
            end
         end
         bdq_pkg::FUNC_POP_BACK: begin
            if (occupancy == 0) res.status = bdq_pkg::STATUS_EMPTY;
            else begin
               occupancy--;
               res.removed_value = ring[slot(occupancy)];
            end
         end
         bdq_pkg::FUNC_PUSH_FRONT: begin
            if (occupancy >= depth) res.status = bdq_pkg::STATUS_FULL;
            else begin
               front = (front + depth - 1) % depth;
               ring[front] = value;
               occupancy++;
            end
         end
         bdq_pkg::FUNC_POP_FRONT: begin
            if (occupancy == 0) res.status = bdq_pkg::STATUS_EMPTY;
            else begin
               res.removed_value = ring[front];
               front = (front + 1) % depth;
               occupancy--;
            end
         end
         bdq_pkg::FUNC_DELETE: begin
            // find the first match from the front, then close the gap
            for (int unsigned i = 0; i < occupancy && !found; i++) begin
               if (ring[slot(i)] == value) begin
                  found = 1'b1;
                  pos = i;
               end
            end
            if (!found) res.status = bdq_pkg::STATUS_NOMATCH;
            else begin
               for (int unsigned i = pos; i + 1 < occupancy; i++)
                  ring[slot(i)] = ring[slot(i + 1)];
               occupancy--;
            end
         end
         default: ;
      endcase
      res.entry_count = 5'(occupancy);
      return res;
   endfunction

   function void note_request(logic [2:0] func, logic [31:0] value);
      deque_result_type res;
      res = step_queue(func, value);
      awaited_results.push_back(res);
      requests_seen++;
      status_seen[res.status]++;
      if (occupancy > peak_occupancy) peak_occupancy = occupancy;
   endfunction

   task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (mismatches < 20)
         $display("tb: mismatch on %s at result %0d: expected %h, got %h",
                  what, results_checked, want, got);
      mismatches++;
   endtask

   task check_response(logic [31:0] removed, logic [4:0] count, logic [1:0] status);
      deque_result_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("unexpected transaction", '0, removed);
         return;
      end
      want = awaited_results.pop_front();
      if (removed !== want.removed_value)
         report_mismatch("removed_value", want.removed_value, removed);
      if (count !== want.entry_count)
         report_mismatch("entry_count", 32'(want.entry_count), 32'(count));
      if (status !== want.status)
         report_mismatch("status", 32'(want.status), 32'(status));
      results_checked++;
   endtask
endclass

module tb;
   localparam int QUEUE_DEPTH  = 16;
   localparam int SEGMENT_LEN  = 40;
   localparam int LONG_HOLD    = 200;
   localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [2:0] FUNC_LAST_CODE = 3'd7;

   typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic [2:0]  req_tuser = '0;   // [2:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [31:0] removed_value, [36:32] entry_count, zero fill
   logic [1:0]  rsp_tuser;        // [1:0] status

   int          tx_idle_pct = 36;
   int          rx_idle_pct = 55;
   int          holds_requested = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int          cycle_count = 0;

   deque_scoreboard sb = new(QUEUE_DEPTH);

   bounded_deque_with_delete #(.DEPTH(QUEUE_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Drive the receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (holds_served != holds_requested) begin
         holds_served <= holds_requested;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Check every result transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata[31:0], rsp_tdata[36:32], rsp_tuser);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // Offer one request after a random gap and hold it until it is taken
   task automatic send_request(input logic [2:0] func, input logic [31:0] value);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(func, value);
   endtask

   // Hold the sender until every expected result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.awaited_results.size() != 0);
   endtask

   // Pick a value: full random, small with many repeats, or an extreme
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = 32'($urandom_range(0, 7)) - 32'd4;
         2: begin
            case ($urandom_range(0, 3))
               0: v = 32'h7fff_ffff;
               1: v = 32'h8000_0000;
               2: v = 32'h0000_0000;
               default: v = 32'hffff_ffff;
            endcase
         end
         default: v = 32'($urandom_range(0, 7)) - 32'd4;
      endcase
      return v;
   endfunction

   // Draw one operation, weighted by the segment's mix
   task automatic pick_item(input op_mix_type mix, output logic [2:0] func,
                            output logic [31:0] value);
      int push_pct;
      int pop_pct;
      int r;
      push_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 20 : 40;
      pop_pct  = (mix == MIX_FILL) ? 10 : (mix == MIX_DRAIN) ? 55 : 35;
      r = $urandom_range(0, 99);
      value = pick_value();
      if (r < 3) begin
         func = 3'($urandom_range(bdq_pkg::FUNC_DELETE + 1, FUNC_LAST_CODE));
      end else if (r < 3 + push_pct) begin
         func = $urandom_range(0, 1) ? bdq_pkg::FUNC_PUSH_FRONT : bdq_pkg::FUNC_PUSH_BACK;
      end else if (r < 3 + push_pct + pop_pct) begin
         func = $urandom_range(0, 1) ? bdq_pkg::FUNC_POP_FRONT : bdq_pkg::FUNC_POP_BACK;
      end else begin
         func = bdq_pkg::FUNC_DELETE;
         // mostly aim at an entry that is held, so deletes hit
         if (sb.occupancy != 0 && $urandom_range(0, 99) < 65)
            value = sb.held_value($urandom_range(0, sb.occupancy - 1));
      end
   endtask

   initial begin
      op_mix_type  plan [6];
      logic [2:0]  func;
      logic [31:0] value;

      plan = '{MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL, MIX_BALANCED, MIX_DRAIN};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty queue, unused codes, extremes, deletes at front, middle, back
      send_request(bdq_pkg::FUNC_POP_BACK, 32'd0);
      send_request(bdq_pkg::FUNC_POP_FRONT, 32'hffff_ffff);
      send_request(bdq_pkg::FUNC_DELETE, 32'd0);
      for (int c = bdq_pkg::FUNC_DELETE + 1; c <= FUNC_LAST_CODE; c++)
         send_request(3'(c), $urandom);
      send_request(bdq_pkg::FUNC_PUSH_BACK, 32'h7fff_ffff);
      send_request(bdq_pkg::FUNC_PUSH_FRONT, 32'h8000_0000);
      send_request(bdq_pkg::FUNC_PUSH_BACK, 32'h0000_0000);
      send_request(bdq_pkg::FUNC_PUSH_BACK, 32'hffff_ffff);
      send_request(bdq_pkg::FUNC_PUSH_FRONT, 32'd5);
      send_request(bdq_pkg::FUNC_PUSH_BACK, 32'd5);
      send_request(bdq_pkg::FUNC_DELETE, 32'd5);
      send_request(bdq_pkg::FUNC_DELETE, 32'h0000_0000);
      send_request(bdq_pkg::FUNC_DELETE, 32'd12345);
      send_request(bdq_pkg::FUNC_DELETE, 32'd5);
      send_request(bdq_pkg::FUNC_POP_FRONT, 32'd0);
      send_request(bdq_pkg::FUNC_POP_BACK, 32'd0);
      send_request(bdq_pkg::FUNC_POP_BACK, 32'd0);
      send_request(bdq_pkg::FUNC_POP_FRONT, 32'd0);
      send_request(bdq_pkg::FUNC_DELETE, 32'h7fff_ffff);

      // Random: three idling phases, each a rotation of fill, mixed and drain segments
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 55 : 0;
         rx_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 36 : 0;
         for (int seg = 0; seg < 6; seg++) begin
            // long receiver hold-off while requests keep coming
            if (seg == 2 && phase != 1)
               holds_requested <= holds_requested + 1;
            for (int n = 0; n < SEGMENT_LEN; n++) begin
               pick_item(plan[seg], func, value);
               send_request(func, value);
            end
         end
         wait_drained();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb: %0d requests, %0d results checked, peak occupancy %0d of %0d",
               sb.requests_seen, sb.results_checked, sb.peak_occupancy, QUEUE_DEPTH);
      $display("tb: statuses ok %0d, empty pop %0d, full push %0d, delete miss %0d",
               sb.status_seen[bdq_pkg::STATUS_OK], sb.status_seen[bdq_pkg::STATUS_EMPTY],
               sb.status_seen[bdq_pkg::STATUS_FULL], sb.status_seen[bdq_pkg::STATUS_NOMATCH]);
      if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
